// ----- design/dofe_pkg.sv -----
// shared types and option codes for the dhcp option field extractor
`timescale 1ns / 1ps

package dofe_pkg;

	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_END    = 8'd255;
	localparam logic [7:0] OPT_SUBNET = 8'd1;
	localparam logic [7:0] OPT_ROUTER = 8'd3;
	localparam logic [7:0] OPT_DNS    = 8'd6;
	localparam logic [7:0] OPT_LEASE  = 8'd51;
	localparam logic [7:0] OPT_TYPE   = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;

	localparam int unsigned NUM_SLOTS = 5;

	localparam logic [2:0] SLOT_SUBNET = 3'd0;
	localparam logic [2:0] SLOT_ROUTER = 3'd1;
	localparam logic [2:0] SLOT_DNS    = 3'd2;
	localparam logic [2:0] SLOT_LEASE  = 3'd3;
	localparam logic [2:0] SLOT_SERVER = 3'd4;

	typedef enum logic [3:0] {
		PH_CODE  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0]  dhcp_type;
		logic [31:0] netmask;
		logic        subnet_valid;
		logic [31:0] router_addr;
		logic        router_valid;
		logic [31:0] dns_server;
		logic        dns_valid;
		logic [31:0] lease_seconds;
		logic        lease_valid;
		logic [31:0] server_id;
		logic        server_valid;
		logic        end_found;
	} result_t;

	typedef struct packed {
		logic emit;
		logic in_done;
	} parse_stat_t;

endpackage

// ----- design/dofe_in_if.sv -----
// input channel: one options byte per word
`timescale 1ns / 1ps

interface dofe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first;
	logic       last;

	modport source (output valid, output data_byte, output first, output last, input ready);
	modport sink (input valid, input data_byte, input first, input last, output ready);
endinterface

// ----- design/dofe_out_if.sv -----
// output channel: at most one extracted option set per packet
`timescale 1ns / 1ps

interface dofe_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  dhcp_type;
	logic [31:0] netmask;
	logic        subnet_valid;
	logic [31:0] router_addr;
	logic        router_valid;
	logic [31:0] dns_server;
	logic        dns_valid;
	logic [31:0] lease_seconds;
	logic        lease_valid;
	logic [31:0] server_id;
	logic        server_valid;
	logic        end_found;

	modport source (
		output valid, input ready,
		output dhcp_type, output netmask, output subnet_valid,
		output router_addr, output router_valid, output dns_server, output dns_valid,
		output lease_seconds, output lease_valid, output server_id, output server_valid,
		output end_found
	);
	modport sink (
		input valid, output ready,
		input dhcp_type, input netmask, input subnet_valid,
		input router_addr, input router_valid, input dns_server, input dns_valid,
		input lease_seconds, input lease_valid, input server_id, input server_valid,
		input end_found
	);
endinterface

// ----- design/dofe_parser.sv -----
// option record walker: parse state, captures and next-result logic
`timescale 1ns / 1ps

module dofe_parser
	import dofe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  data_byte,
	input  logic        first,
	input  logic        last,
	output parse_stat_t stat,
	output result_t     res
);

	phase_t      phase_q, phase_c, phase_n;
	logic [7:0]  code_q, code_c, code_n;
	logic [7:0]  left_q, left_c, left_n;
	logic [2:0]  cnt_q, cnt_c, cnt_n;
	logic [31:0] shift_q, shift_c, shift_n;
	logic        tseen_q, tseen_c, tseen_n;
	logic [7:0]  tval_q, tval_c, tval_n;
	logic [31:0] cap_q [NUM_SLOTS];
	logic [31:0] cap_c [NUM_SLOTS];
	logic [31:0] cap_n [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] flags_q, flags_c, flags_n;
	logic        emit;
	logic        end_f;

	always_comb begin
		// first clears the whole state before the byte is taken
		phase_c = first ? PH_CODE : phase_q;
		code_c  = first ? 8'd0 : code_q;
		left_c  = first ? 8'd0 : left_q;
		cnt_c   = first ? 3'd0 : cnt_q;
		shift_c = first ? 32'd0 : shift_q;
		tseen_c = first ? 1'b0 : tseen_q;
		tval_c  = first ? 8'd0 : tval_q;
		flags_c = first ? '0 : flags_q;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			cap_c[i] = first ? 32'd0 : cap_q[i];
		end

		phase_n = phase_c;
		code_n  = code_c;
		left_n  = left_c;
		cnt_n   = cnt_c;
		shift_n = shift_c;
		tseen_n = tseen_c;
		tval_n  = tval_c;
		flags_n = flags_c;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			cap_n[i] = cap_c[i];
		end
		emit  = 1'b0;
		end_f = 1'b0;

		unique case (phase_c)
			PH_CODE: begin
				if (data_byte == OPT_END) begin
					emit    = 1'b1;
					end_f   = 1'b1;
					phase_n = PH_DONE;
				end else if (data_byte != OPT_PAD) begin
					code_n  = data_byte;
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				left_n  = data_byte;
				cnt_n   = 3'd0;
				shift_n = 32'd0;
				phase_n = (data_byte == 8'd0) ? PH_CODE : PH_VALUE;
			end
			PH_VALUE: begin
				if (cnt_c < 3'd4) begin
					shift_n = {shift_c[23:0], data_byte};
				end
				if (cnt_c < 3'd5) begin
					cnt_n = cnt_c + 3'd1;
				end
				left_n = left_c - 8'd1;
				if (left_n == 8'd0) begin
					if (code_c == OPT_TYPE && cnt_n == 3'd1 && !tseen_c) begin
						tseen_n = 1'b1;
						tval_n  = shift_n[7:0];
					end
					// exact length four options
					if (cnt_n == 3'd4) begin
						if (code_c == OPT_SUBNET) begin
							cap_n[SLOT_SUBNET]   = shift_n;
							flags_n[SLOT_SUBNET] = 1'b1;
						end else if (code_c == OPT_LEASE) begin
							cap_n[SLOT_LEASE]   = shift_n;
							flags_n[SLOT_LEASE] = 1'b1;
						end else if (code_c == OPT_SERVER) begin
							cap_n[SLOT_SERVER]   = shift_n;
							flags_n[SLOT_SERVER] = 1'b1;
						end
					end
					phase_n = PH_CODE;
				end
				// router and dns take the fourth byte as it arrives
				if (cnt_c == 3'd3) begin
					if (code_c == OPT_ROUTER) begin
						cap_n[SLOT_ROUTER]   = shift_n;
						flags_n[SLOT_ROUTER] = 1'b1;
					end else if (code_c == OPT_DNS) begin
						cap_n[SLOT_DNS]   = shift_n;
						flags_n[SLOT_DNS] = 1'b1;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (phase_c != PH_DONE && !emit && last) begin
			emit    = 1'b1;
			end_f   = 1'b0;
			phase_n = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			code_q  <= 8'd0;
			left_q  <= 8'd0;
			cnt_q   <= 3'd0;
			shift_q <= 32'd0;
			tseen_q <= 1'b0;
			tval_q  <= 8'd0;
			flags_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cap_q[i] <= 32'd0;
			end
		end else if (step_en) begin
			phase_q <= phase_n;
			code_q  <= code_n;
			left_q  <= left_n;
			cnt_q   <= cnt_n;
			shift_q <= shift_n;
			tseen_q <= tseen_n;
			tval_q  <= tval_n;
			flags_q <= flags_n;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cap_q[i] <= cap_n[i];
			end
		end
	end

	assign stat.emit    = emit;
	assign stat.in_done = (phase_c == PH_DONE);

	assign res.dhcp_type     = tseen_n ? tval_n : 8'd0;
	assign res.netmask       = cap_n[SLOT_SUBNET];
	assign res.subnet_valid  = flags_n[SLOT_SUBNET];
	assign res.router_addr   = cap_n[SLOT_ROUTER];
	assign res.router_valid  = flags_n[SLOT_ROUTER];
	assign res.dns_server    = cap_n[SLOT_DNS];
	assign res.dns_valid     = flags_n[SLOT_DNS];
	assign res.lease_seconds = cap_n[SLOT_LEASE];
	assign res.lease_valid   = flags_n[SLOT_LEASE];
	assign res.server_id     = cap_n[SLOT_SERVER];
	assign res.server_valid  = flags_n[SLOT_SERVER];
	assign res.end_found     = end_f;

endmodule

// ----- design/dhcp_option_field_extractor.sv -----
// top level: input register, option parser and result register
//
// channel   dir  word                       payload
// options   in   one options byte           data_byte[7:0], first, last
// result    out  at most one set per packet dhcp_type .. server_valid, end_found
//
// one byte is taken every cycle while no closing byte is held; a result enters the result
// register when the byte that closes the packet steps out of the input register
// the rate is set by the single parse step between the input and result registers
// arst_n clears the parse state to expect a code and empties both registers
// a byte that closes a packet waits in the input register while an earlier result
// is not yet taken; other bytes keep flowing
`timescale 1ns / 1ps

module dhcp_option_field_extractor
	import dofe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dofe_in_if.sink    options,
	dofe_out_if.source result
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;
	logic        adv;
	logic        out_valid_q;
	result_t     res_q;
	result_t     res_c;
	parse_stat_t stat;

	dofe_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv),
		.data_byte (byte_s1),
		.first     (first_s1),
		.last      (last_s1),
		.stat      (stat),
		.res       (res_c)
	);

	// hold the word only when it would emit into a full, stalled result register
	assign adv           = v_s1 && !(stat.emit && out_valid_q && !result.ready);
	assign options.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (options.ready) begin
			v_s1 <= options.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (options.ready && options.valid) begin
			byte_s1  <= options.data_byte;
			first_s1 <= options.first;
			last_s1  <= options.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stat.emit) begin
			res_q <= res_c;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.dhcp_type     = res_q.dhcp_type;
	assign result.netmask       = res_q.netmask;
	assign result.subnet_valid  = res_q.subnet_valid;
	assign result.router_addr   = res_q.router_addr;
	assign result.router_valid  = res_q.router_valid;
	assign result.dns_server    = res_q.dns_server;
	assign result.dns_valid     = res_q.dns_valid;
	assign result.lease_seconds = res_q.lease_seconds;
	assign result.lease_valid   = res_q.lease_valid;
	assign result.server_id     = res_q.server_id;
	assign result.server_valid  = res_q.server_valid;
	assign result.end_found     = res_q.end_found;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && stat.emit && out_valid_q && !result.ready |-> !options.ready)
		else $error("closing word advanced into a stalled result register");

	a_emit_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && stat.emit |=> out_valid_q)
		else $error("emitted result not held in result register");

	a_done_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && stat.in_done |-> !stat.emit)
		else $error("result emitted after packet already closed");

endmodule

// ----- sim/testbench.sv -----
// self-checking bench for the dhcp option field extractor: byte stream in, option sets checked
`timescale 1ns / 1ps

module testbench
	import dofe_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;

	// walks the option records the way the block should and keeps the sets still due
	class dhcp_option_tracker;
		phase_t               phase;
		logic [7:0]           code;
		logic [7:0]           left;
		logic [2:0]           count;
		logic [31:0]          shift;
		logic                 type_seen;
		logic [7:0]           type_value;
		logic [31:0]          fields [NUM_SLOTS];
		logic [NUM_SLOTS-1:0] flags;
		result_t              pending_sets [$];
		int                   errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_CODE;
			code = '0;
			left = '0;
			count = '0;
			shift = '0;
			type_seen = 1'b0;
			type_value = '0;
			flags = '0;
			for (int i = 0; i < NUM_SLOTS; i++)
				fields[i] = '0;
		endfunction

		function void capture(logic [2:0] slot);
			fields[slot] = shift;
			flags[slot] = 1'b1;
		endfunction

		function void push_set(logic end_found);
			result_t r;
			r.dhcp_type = type_seen ? type_value : 8'd0;
			r.netmask = fields[SLOT_SUBNET];
			r.subnet_valid = flags[SLOT_SUBNET];
			r.router_addr = fields[SLOT_ROUTER];
			r.router_valid = flags[SLOT_ROUTER];
			r.dns_server = fields[SLOT_DNS];
			r.dns_valid = flags[SLOT_DNS];
			r.lease_seconds = fields[SLOT_LEASE];
			r.lease_valid = flags[SLOT_LEASE];
			r.server_id = fields[SLOT_SERVER];
			r.server_valid = flags[SLOT_SERVER];
			r.end_found = end_found;
			pending_sets.push_back(r);
		endfunction

		function void take_byte(logic [7:0] b, logic is_first, logic is_last);
			logic [2:0] prev;
			if (is_first)
				clear();
			if (phase == PH_DONE)
				return;
			case (phase)
				PH_CODE: begin
					if (b == OPT_END) begin
						push_set(1'b1);
						phase = PH_DONE;
						return;
					end
					if (b != OPT_PAD) begin
						code = b;
						phase = PH_LEN;
					end
				end
				PH_LEN: begin
					left = b;
					count = '0;
					shift = '0;
					phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
				end
				default: begin
					prev = count;
					if (count < 3'd4)
						shift = {shift[23:0], b};
					if (count < 3'd5)
						count = count + 3'd1;
					left = left - 8'd1;
					if (left == 8'd0) begin
						if (code == OPT_TYPE && count == 3'd1 && !type_seen) begin
							type_seen = 1'b1;
							type_value = shift[7:0];
						end
						if (count == 3'd4) begin
							if (code == OPT_SUBNET)
								capture(SLOT_SUBNET);
							else if (code == OPT_LEASE)
								capture(SLOT_LEASE);
							else if (code == OPT_SERVER)
								capture(SLOT_SERVER);
						end
						phase = PH_CODE;
					end
					// router and dns latch on their fourth value byte, even if cut short later
					if (prev == 3'd3 && count == 3'd4) begin
						if (code == OPT_ROUTER)
							capture(SLOT_ROUTER);
						else if (code == OPT_DNS)
							capture(SLOT_DNS);
					end
				end
			endcase
			if (is_last) begin
				push_set(1'b0);
				phase = PH_DONE;
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				errors++;
				$display("%0t: %s expected %h got %h", $time, name, want, seen);
			end
		endfunction

		function void compare_set(result_t got);
			result_t want;
			if (pending_sets.size() == 0) begin
				errors++;
				$display("%0t: unexpected option set, expected none got %h", $time, got);
				return;
			end
			want = pending_sets.pop_front();
			check_field("dhcp_type", 32'(want.dhcp_type), 32'(got.dhcp_type));
			check_field("netmask", want.netmask, got.netmask);
			check_field("subnet_valid", 32'(want.subnet_valid), 32'(got.subnet_valid));
			check_field("router_addr", want.router_addr, got.router_addr);
			check_field("router_valid", 32'(want.router_valid), 32'(got.router_valid));
			check_field("dns_server", want.dns_server, got.dns_server);
			check_field("dns_valid", 32'(want.dns_valid), 32'(got.dns_valid));
			check_field("lease_seconds", want.lease_seconds, got.lease_seconds);
			check_field("lease_valid", 32'(want.lease_valid), 32'(got.lease_valid));
			check_field("server_id", want.server_id, got.server_id);
			check_field("server_valid", 32'(want.server_valid), 32'(got.server_valid));
			check_field("end_found", 32'(want.end_found), 32'(got.end_found));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dofe_in_if  options_ch ();
	dofe_out_if result_ch ();

	dhcp_option_field_extractor u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.options (options_ch),
		.result  (result_ch)
	);

	dhcp_option_tracker tracker = new();

	int         send_idle_pct;
	int         stall_pct;
	int         hold_requests;
	int         bytes_sent;
	logic [7:0] pkt_bytes [$];
	bit         pkt_last;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [7:0] pick_value_byte();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// one packet of option records with random content, ended in one of several ways
	function automatic void build_packet();
		int         len;
		int         cut;
		logic [7:0] code;
		pkt_bytes.delete();
		pkt_last = 1'b0;
		repeat ($urandom_range(1, 5)) begin
			case ($urandom_range(0, 9))
				0: code = OPT_SUBNET;
				1: code = OPT_ROUTER;
				2: code = OPT_DNS;
				3: code = OPT_LEASE;
				4: code = OPT_TYPE;
				5: code = OPT_SERVER;
				6: code = 8'd50;
				7: code = 8'($urandom_range(1, 254));
				default: code = OPT_PAD;
			endcase
			pkt_bytes.push_back(code);
			if (code != OPT_PAD) begin
				if (code == OPT_TYPE)
					len = 1;
				else if (code == OPT_ROUTER || code == OPT_DNS)
					len = 4 * $urandom_range(1, 2);
				else if (code == OPT_SUBNET || code == OPT_LEASE || code == OPT_SERVER)
					len = 4;
				else
					len = $urandom_range(0, 6);
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(0, 7);
				if ($urandom_range(0, 59) == 0)
					len = $urandom_range(128, 255);
				pkt_bytes.push_back(8'(len));
				repeat (len)
					pkt_bytes.push_back(pick_value_byte());
			end
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				pkt_bytes.push_back(OPT_END);
				// trailing bytes after the end mark must be ignored
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						pkt_bytes.push_back(pick_value_byte());
				pkt_last = 1'($urandom_range(0, 1));
			end
			6, 7: begin
				cut = $urandom_range(1, pkt_bytes.size());
				while (pkt_bytes.size() > cut)
					void'(pkt_bytes.pop_back());
				pkt_last = 1'b1;
			end
			8: begin
				pkt_last = 1'b1;
			end
			default: begin
				pkt_last = 1'b0;
			end
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b, logic is_first, logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			options_ch.valid <= 1'b0;
			@(posedge clk);
		end
		options_ch.valid <= 1'b1;
		options_ch.data_byte <= b;
		options_ch.first <= is_first;
		options_ch.last <= is_last;
		do
			@(posedge clk);
		while (!options_ch.ready);
		tracker.take_byte(b, is_first, is_last);
		bytes_sent++;
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt_bytes.size(); i++)
			send_byte(pkt_bytes[i], i == 0, pkt_last && i == pkt_bytes.size() - 1);
	endtask

	initial begin : receiver
		int hold_left;
		int holds_done;
		result_ch.ready = 1'b0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t got;
		if (result_ch.valid && result_ch.ready) begin
			got.dhcp_type = result_ch.dhcp_type;
			got.netmask = result_ch.netmask;
			got.subnet_valid = result_ch.subnet_valid;
			got.router_addr = result_ch.router_addr;
			got.router_valid = result_ch.router_valid;
			got.dns_server = result_ch.dns_server;
			got.dns_valid = result_ch.dns_valid;
			got.lease_seconds = result_ch.lease_seconds;
			got.lease_valid = result_ch.lease_valid;
			got.server_id = result_ch.server_id;
			got.server_valid = result_ch.server_valid;
			got.end_found = result_ch.end_found;
			tracker.compare_set(got);
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((options_ch.valid && options_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int idle_tbl [4];
		int stall_tbl [4];
		idle_tbl = '{0, 83, 0, 9};
		stall_tbl = '{0, 0, 83, 9};
		arst_n = 1'b0;
		options_ch.valid = 1'b0;
		options_ch.data_byte = '0;
		options_ch.first = 1'b0;
		options_ch.last = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_requests = 0;
		bytes_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// end mark that is also the last byte
		pkt_bytes = '{OPT_END};
		pkt_last = 1'b1;
		send_packet();
		// pad, end value inside a record, extreme mask bytes, zero length
		pkt_bytes = '{OPT_PAD, OPT_TYPE, 8'd1, OPT_END, OPT_SUBNET, 8'd4, 8'hFF, 8'h00,
			8'hFF, 8'h00, OPT_ROUTER, 8'd0, OPT_END};
		pkt_last = 1'b0;
		send_packet();
		// dns cut short after its fifth value byte still counts
		pkt_bytes = '{OPT_DNS, 8'd6, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE};
		pkt_last = 1'b1;
		send_packet();
		// exact-length option cut short is dropped
		pkt_bytes = '{OPT_SERVER, 8'd4, 8'h01, 8'h02};
		pkt_last = 1'b1;
		send_packet();
		// packet already closed: these words must be ignored
		send_byte(OPT_END, 1'b0, 1'b0);
		send_byte(OPT_END, 1'b0, 1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_tbl[ph];
			stall_pct = stall_tbl[ph];
			if (ph == 0) begin
				// long receiver hold while short packets keep coming, so the input backs up
				hold_requests++;
				repeat (30) begin
					pkt_bytes = '{OPT_TYPE, 8'd1, pick_value_byte(), OPT_END};
					pkt_last = 1'b0;
					send_packet();
				end
			end
			while (bytes_sent < 150 + (ph + 1) * 400) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 6))
						send_byte(pick_value_byte(), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
				end else begin
					build_packet();
					send_packet();
				end
			end
		end
		options_ch.valid <= 1'b0;

		while (tracker.pending_sets.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
design/dofe_pkg.sv
design/dofe_in_if.sv
design/dofe_out_if.sv
design/dofe_parser.sv
design/dhcp_option_field_extractor.sv
sim/testbench.sv
